>>> design/gfbl_pkg.sv
// Shared constants, types and datapath command/status structs for the grouped free block list.
`default_nettype none

package gfbl_pkg;

  localparam int unsigned GROUP_SIZE  = 64;
  localparam int unsigned BLOCK_COUNT = 1024;

  localparam int unsigned REC_WORDS   = GROUP_SIZE + 1;
  localparam int unsigned SPILL_DEPTH = BLOCK_COUNT * REC_WORDS;

  localparam int unsigned BLK_W = 10;
  localparam int unsigned CNT_W = $clog2(GROUP_SIZE + 2);
  localparam int unsigned GA_W  = $clog2(GROUP_SIZE);
  localparam int unsigned SA_W  = $clog2(SPILL_DEPTH);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_BAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP_WAIT,
    ST_SPILL,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_EMPTY,
    RES_BAD,
    RES_POP,
    RES_LINK
  } res_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     decide;
    logic     push;
    logic     pop_rd;
    logic     spill_step;
    logic     fill_step;
    logic     idx_clr;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic act;
    logic bad;
    logic full;
    logic empty;
    logic link_bad;
    logic spill_last;
    logic fill_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/gfbl_dpath.sv
// Datapath: head group count, link, group memory, spill store and result registers.
`default_nettype none

module gfbl_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gfbl_pkg::dp_cmd_t            cmd_i,
  output gfbl_pkg::dp_stat_t                stat_o,
  input  wire logic                         action_i,
  input  wire logic [gfbl_pkg::BLK_W-1:0]   block_index_i,
  output logic      [gfbl_pkg::BLK_W-1:0]   granted_block_o,
  output logic      [1:0]                   status_o
);

  localparam int unsigned BLK_W = gfbl_pkg::BLK_W;
  localparam int unsigned CNT_W = gfbl_pkg::CNT_W;
  localparam int unsigned GA_W  = gfbl_pkg::GA_W;
  localparam int unsigned SA_W  = gfbl_pkg::SA_W;

  localparam logic [CNT_W-1:0] CntFull     = CNT_W'(gfbl_pkg::REC_WORDS);
  localparam logic [CNT_W-1:0] CntGroup    = CNT_W'(gfbl_pkg::GROUP_SIZE);
  localparam logic [CNT_W-1:0] CntFillLast = CNT_W'(gfbl_pkg::GROUP_SIZE + 1);
  localparam logic [CNT_W-1:0] CntOne      = CNT_W'(1);
  localparam logic [CNT_W-1:0] CntTwo      = CNT_W'(2);

  logic [BLK_W-1:0] grp_mem   [gfbl_pkg::GROUP_SIZE];
  logic [BLK_W-1:0] spill_mem [gfbl_pkg::SPILL_DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [BLK_W-1:0] link_q, link_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic             item_act_q;
  logic [BLK_W-1:0] item_blk_q;
  logic [SA_W-1:0]  base_q;

  logic [BLK_W-1:0]      res_granted_q;
  gfbl_pkg::status_e     res_status_q;
  logic [BLK_W-1:0]      out_granted_q;
  gfbl_pkg::status_e     out_status_q;

  logic             grp_rd_en, grp_wr_en;
  logic [GA_W-1:0]  grp_rd_addr, grp_wr_addr;
  logic [BLK_W-1:0] grp_wr_data, grp_rdata_q;

  logic             spill_rd_en, spill_wr_en;
  logic [SA_W-1:0]  spill_addr;
  logic [BLK_W-1:0] spill_wr_data, spill_rdata_q;

  logic [BLK_W-1:0] base_src;

  assign stat_o.act        = item_act_q;
  assign stat_o.bad        = (item_blk_q == '0) ||
                             (32'(item_blk_q) >= 32'(gfbl_pkg::BLOCK_COUNT));
  assign stat_o.full       = (count_q >= CntFull);
  assign stat_o.empty      = (count_q <= CntOne);
  assign stat_o.link_bad   = (link_q == '0) ||
                             (32'(link_q) >= 32'(gfbl_pkg::BLOCK_COUNT));
  assign stat_o.spill_last = (idx_q == CntGroup);
  assign stat_o.fill_last  = (idx_q == CntFillLast);

  // Group memory ports: pop and spill read, push and refill write.
  always_comb begin
    grp_rd_en   = cmd_i.pop_rd || (cmd_i.spill_step && (idx_q < CntGroup));
    grp_rd_addr = cmd_i.pop_rd ? GA_W'(count_q - CntTwo) : GA_W'(idx_q);
    grp_wr_en   = 1'b0;
    grp_wr_addr = GA_W'(count_q - CntOne);
    grp_wr_data = item_blk_q;
    if (cmd_i.push) begin
      grp_wr_en = 1'b1;
    end else if (cmd_i.fill_step && (idx_q >= CntTwo)) begin
      grp_wr_en   = 1'b1;
      grp_wr_addr = GA_W'(idx_q - CntTwo);
      grp_wr_data = spill_rdata_q;
    end
  end

  // Spill store: word 0 of a record is the link, the rest follow the group entries.
  always_comb begin
    spill_addr    = base_q + SA_W'(idx_q);
    spill_wr_en   = cmd_i.spill_step;
    spill_wr_data = (idx_q == '0) ? link_q : grp_rdata_q;
    spill_rd_en   = cmd_i.fill_step && (idx_q <= CntGroup);
  end

  always_ff @(posedge clk_i) begin
    if (grp_wr_en) begin
      grp_mem[grp_wr_addr] <= grp_wr_data;
    end
    if (grp_rd_en) begin
      grp_rdata_q <= grp_mem[grp_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (spill_wr_en) begin
      spill_mem[spill_addr] <= spill_wr_data;
    end
    if (spill_rd_en) begin
      spill_rdata_q <= spill_mem[spill_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    link_d  = link_q;
    idx_d   = idx_q;
    if (cmd_i.push) begin
      count_d = count_q + CntOne;
    end
    if (cmd_i.pop_rd) begin
      count_d = count_q - CntOne;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.spill_step) begin
      idx_d = idx_q + CntOne;
      if (stat_o.spill_last) begin
        count_d = CntOne;
        link_d  = item_blk_q;
      end
    end
    if (cmd_i.fill_step) begin
      idx_d = idx_q + CntOne;
      if (idx_q == CntOne) begin
        link_d = spill_rdata_q;
      end
      if (stat_o.fill_last) begin
        count_d = CntFull;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntOne;
      link_q  <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      link_q  <= link_d;
      idx_q   <= idx_d;
    end
  end

  assign base_src = item_act_q ? item_blk_q : link_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_act_q <= action_i;
      item_blk_q <= block_index_i;
    end
    if (cmd_i.decide) begin
      base_q <= SA_W'(base_src) * SA_W'(gfbl_pkg::REC_WORDS);
    end
    case (cmd_i.res_sel)
      gfbl_pkg::RES_OK: begin
        res_granted_q <= '0;
        res_status_q  <= gfbl_pkg::STATUS_OK;
      end
      gfbl_pkg::RES_EMPTY: begin
        res_granted_q <= '0;
        res_status_q  <= gfbl_pkg::STATUS_EMPTY;
      end
      gfbl_pkg::RES_BAD: begin
        res_granted_q <= '0;
        res_status_q  <= gfbl_pkg::STATUS_BAD;
      end
      gfbl_pkg::RES_POP: begin
        res_granted_q <= grp_rdata_q;
        res_status_q  <= gfbl_pkg::STATUS_OK;
      end
      gfbl_pkg::RES_LINK: begin
        res_granted_q <= link_q;
        res_status_q  <= gfbl_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_granted_q <= res_granted_q;
      out_status_q  <= res_status_q;
    end
  end

  assign granted_block_o = out_granted_q;
  assign status_o        = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntOne) && (count_q <= CntFull))
    else $error("group count out of range");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q < CntFull))
    else $error("push into a full group");

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_rd |-> (count_q >= CntTwo))
    else $error("pop from a group holding only the link");

  a_spill_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.spill_step && stat_o.spill_last) |=>
      ((count_q == CntOne) && (link_q == item_blk_q)))
    else $error("group did not restart on the freed block after a spill");

endmodule

`default_nettype wire

>>> design/gfbl_ctrl.sv
// Controller: sequences push, pop, spill and refill, and owns both handshakes.
`default_nettype none

module gfbl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire gfbl_pkg::dp_stat_t stat_i,
  output gfbl_pkg::dp_cmd_t       cmd_o
);

  gfbl_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == gfbl_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfbl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    cmd_o.load_item    = 1'b0;
    cmd_o.decide       = 1'b0;
    cmd_o.push         = 1'b0;
    cmd_o.pop_rd       = 1'b0;
    cmd_o.spill_step   = 1'b0;
    cmd_o.fill_step    = 1'b0;
    cmd_o.idx_clr      = 1'b0;
    cmd_o.res_sel      = gfbl_pkg::RES_NONE;
    cmd_o.out_load     = 1'b0;
    case (state_q)
      gfbl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = gfbl_pkg::ST_DECIDE;
        end
      end
      gfbl_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.act) begin
          if (stat_i.bad) begin
            cmd_o.res_sel = gfbl_pkg::RES_BAD;
            state_d       = gfbl_pkg::ST_DONE;
          end else if (!stat_i.full) begin
            cmd_o.push    = 1'b1;
            cmd_o.res_sel = gfbl_pkg::RES_OK;
            state_d       = gfbl_pkg::ST_DONE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.res_sel = gfbl_pkg::RES_OK;
            state_d       = gfbl_pkg::ST_SPILL;
          end
        end else begin
          if (!stat_i.empty) begin
            cmd_o.pop_rd = 1'b1;
            state_d      = gfbl_pkg::ST_POP_WAIT;
          end else if (stat_i.link_bad) begin
            cmd_o.res_sel = gfbl_pkg::RES_EMPTY;
            state_d       = gfbl_pkg::ST_DONE;
          end else begin
            // Hand out the linked block before the refill overwrites the link.
            cmd_o.idx_clr = 1'b1;
            cmd_o.res_sel = gfbl_pkg::RES_LINK;
            state_d       = gfbl_pkg::ST_FILL;
          end
        end
      end
      gfbl_pkg::ST_POP_WAIT: begin
        cmd_o.res_sel = gfbl_pkg::RES_POP;
        state_d       = gfbl_pkg::ST_DONE;
      end
      gfbl_pkg::ST_SPILL: begin
        cmd_o.spill_step = 1'b1;
        if (stat_i.spill_last) begin
          state_d = gfbl_pkg::ST_DONE;
        end
      end
      gfbl_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = gfbl_pkg::ST_DONE;
        end
      end
      gfbl_pkg::ST_DONE: begin
        // Hold the result until the output register has room.
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = gfbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gfbl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/grouped_free_block_list.sv
// Grouped free block list allocator: top level joining controller and datapath.
//
// Input channel (in_valid_i / in_ready_o) takes one beat per request: action_i 0
// allocates a block, 1 frees block_index_i. Output channel (out_valid_o /
// out_ready_i) returns exactly one beat per request: granted_block_o and status_o
// (0 ok, 1 no free block, 2 freed number zero or out of range).
// One request is worked at a time. A push, a bad free or an empty allocate goes
// from DECIDE to DONE, a pop through POP_WAIT in between. A free into a full
// group copies GROUP_SIZE + 1 words to the spill store and an allocate on an
// empty group with a valid link copies them back, one word per cycle over the
// single port of the spill store.
// A new request is taken in the cycle after its predecessor's result is loaded
// into the output register, even while that result still waits to be taken.
// If the receiver stalls, the result holds in the output register and the next
// finished result waits in the controller until the register frees up.
// Reset empties the head group (link 0, count 1); the spill store is not cleared
// and holds nothing meaningful until a full group is spilled into it.
`default_nettype none

module grouped_free_block_list (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       action_i,
  input  wire logic [gfbl_pkg::BLK_W-1:0] block_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [gfbl_pkg::BLK_W-1:0] granted_block_o,
  output logic      [1:0]                 status_o
);

  gfbl_pkg::dp_cmd_t  cmd;
  gfbl_pkg::dp_stat_t stat;

  gfbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gfbl_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .block_index_i   (block_index_i),
    .granted_block_o (granted_block_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire
